### rtl/m2cbc_pkg.sv
// Shared types and constants for the MULTI2 CBC/OFB decryption block.
// Used by the front end, the job queue, the round engine and the top level.
// No dependencies.
package m2cbc_pkg;

    localparam int BLOCK_W     = 64;
    localparam int HALF_W      = 32;
    localparam int COUNT_W     = 4;
    localparam int TDATA_W     = 72;   // block + count, padded to whole bytes
    localparam int CFG_INDEX_W = 3;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_12 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_34 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_56 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_78 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IV     = 3'd4;

    localparam int DEFAULT_ROUNDS = 4;
    localparam int QUEUE_DEPTH    = 2;

    // What the back end has to do with one item
    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,   // no bytes: empty result
        MODE_OFB  = 2'd1,   // short residual: encrypt chain, xor leading bytes
        MODE_CBC  = 2'd2    // full block: decrypt, xor chain
    } mode_t;

    // Work key words, word one in the upper half of w12
    typedef struct packed {
        logic [BLOCK_W-1:0] w12;
        logic [BLOCK_W-1:0] w34;
        logic [BLOCK_W-1:0] w56;
        logic [BLOCK_W-1:0] w78;
    } key_set_t;

    // One classified item, passed from front to back
    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] count;
        logic [BLOCK_W-1:0] block;
        logic [BLOCK_W-1:0] chain;
    } job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/m2cbc_front.sv
// Front end: configuration registers, chaining register and item classification.
// Pushes one job per accepted beat into the job queue. Depends on m2cbc_pkg.
module m2cbc_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [m2cbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [m2cbc_pkg::BLOCK_W-1:0]          cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [m2cbc_pkg::TDATA_W-1:0]          s_tdata,   // cipher_block, byte_count, pad
    input  logic                                   s_tuser,   // packet_start
    input  m2cbc_pkg::queue_status_t               q_status,
    output logic                                   q_push,
    output m2cbc_pkg::job_t                        q_job,
    output m2cbc_pkg::key_set_t                    keys
);

    m2cbc_pkg::key_set_t                 key_reg, key_next;
    logic [m2cbc_pkg::BLOCK_W-1:0]       iv_reg, iv_next;
    logic [m2cbc_pkg::BLOCK_W-1:0]       chain_reg, chain_next;
    logic [m2cbc_pkg::BLOCK_W-1:0]       in_block;
    logic [m2cbc_pkg::COUNT_W-1:0]       in_count;
    logic [m2cbc_pkg::BLOCK_W-1:0]       chain_use;
    logic                                accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign keys      = key_reg;

    assign in_block  = s_tdata[m2cbc_pkg::BLOCK_W-1:0];
    assign in_count  = s_tdata[m2cbc_pkg::BLOCK_W +: m2cbc_pkg::COUNT_W];
    // packet start takes the IV in place of the running chain
    assign chain_use = s_tuser ? iv_reg : chain_reg;

    // classify the beat
    always_comb begin
        q_job.block = in_block;
        q_job.chain = chain_use;
        if (in_count == '0) begin
            q_job.mode  = m2cbc_pkg::MODE_ZERO;
            q_job.count = '0;
        end else if (in_count >= m2cbc_pkg::FULL_COUNT) begin
            q_job.mode  = m2cbc_pkg::MODE_CBC;
            q_job.count = m2cbc_pkg::FULL_COUNT;
        end else begin
            q_job.mode  = m2cbc_pkg::MODE_OFB;
            q_job.count = in_count;
        end
    end

    assign q_push = accept;

    // register writes
    always_comb begin
        key_next = key_reg;
        iv_next  = iv_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                m2cbc_pkg::CFG_KEY_12: key_next.w12 = cfg_data;
                m2cbc_pkg::CFG_KEY_34: key_next.w34 = cfg_data;
                m2cbc_pkg::CFG_KEY_56: key_next.w56 = cfg_data;
                m2cbc_pkg::CFG_KEY_78: key_next.w78 = cfg_data;
                m2cbc_pkg::CFG_IV:     iv_next      = cfg_data;
                default: ;
            endcase
        end
    end

    // chain: raw ciphertext after a full block, else whatever was in use
    always_comb begin
        chain_next = chain_reg;
        if (accept) begin
            chain_next = (q_job.mode == m2cbc_pkg::MODE_CBC) ? in_block : chain_use;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            iv_reg    <= '0;
            chain_reg <= '0;
        end else begin
            key_reg   <= key_next;
            iv_reg    <= iv_next;
            chain_reg <= chain_next;
        end
    end

endmodule

### rtl/m2cbc_queue.sv
// Short job queue between front end and round engine.
// Register based FIFO of m2cbc_pkg::job_t entries. Depends on m2cbc_pkg.
module m2cbc_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  m2cbc_pkg::job_t           push_job,
    input  logic                      pop,
    output m2cbc_pkg::job_t           pop_job,
    output m2cbc_pkg::queue_status_t  status
);

    localparam int DEPTH = m2cbc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    m2cbc_pkg::job_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                do_push, do_pop;

    assign status.full  = (fill_reg == CNT_W'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/m2cbc_engine.sv
// Round engine: one MULTI2 pi function per cycle, decrypt or encrypt order,
// then chain/keystream xor into the output register. Depends on m2cbc_pkg.
module m2cbc_engine #(
    parameter int ROUNDS = m2cbc_pkg::DEFAULT_ROUNDS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  m2cbc_pkg::key_set_t                    keys,
    input  m2cbc_pkg::queue_status_t               q_status,
    output logic                                   q_pop,
    input  m2cbc_pkg::job_t                        q_job,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [m2cbc_pkg::TDATA_W-1:0]          m_tdata    // plain_block, plain_count, pad
);

    localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int HW    = m2cbc_pkg::HALF_W;
    localparam int BW    = m2cbc_pkg::BLOCK_W;
    localparam int CW    = m2cbc_pkg::COUNT_W;
    localparam logic [2:0] STEP_LAST = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        OP_PI1 = 2'd0,
        OP_PI2 = 2'd1,
        OP_PI3 = 2'd2,
        OP_PI4 = 2'd3
    } op_t;

    function automatic logic [HW-1:0] rotl(input logic [HW-1:0] v, input int unsigned n);
        return (v << n) | (v >> (HW - n));
    endfunction

    // keep the leading count bytes
    function automatic logic [BW-1:0] lead_mask(input logic [CW-1:0] count);
        logic [BW-1:0] m;
        for (int i = 0; i < 8; i++) begin
            m[BW-1-8*i -: 8] = (CW'(i) < count) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    state_t              state_reg, state_next;
    m2cbc_pkg::job_t     job_reg, job_next;
    logic [HW-1:0]       l_reg, l_next, r_reg, r_next;
    logic [2:0]          step_reg, step_next;
    logic [RND_W-1:0]    round_reg, round_next;
    logic                out_valid_reg, out_valid_next;
    logic [m2cbc_pkg::TDATA_W-1:0] out_data_reg, out_data_next;

    op_t                 op;
    logic [HW-1:0]       ka, kb;
    logic [HW-1:0]       l_step, r_step;
    logic [HW-1:0]       y, z, a, b, c;
    logic                last_step, out_free, can_pop;
    logic [BW-1:0]       result;

    logic [HW-1:0] k1, k2, k3, k4, k5, k6, k7, k8;
    assign k1 = keys.w12[BW-1:HW];
    assign k2 = keys.w12[HW-1:0];
    assign k3 = keys.w34[BW-1:HW];
    assign k4 = keys.w34[HW-1:0];
    assign k5 = keys.w56[BW-1:HW];
    assign k6 = keys.w56[HW-1:0];
    assign k7 = keys.w78[BW-1:HW];
    assign k8 = keys.w78[HW-1:0];

    // step schedule: decrypt runs the key words backwards
    always_comb begin
        op = OP_PI1;
        ka = '0;
        kb = '0;
        if (job_reg.mode == m2cbc_pkg::MODE_CBC) begin
            case (step_reg)
                3'd0: begin op = OP_PI4; ka = k8; end
                3'd1: begin op = OP_PI3; ka = k6; kb = k7; end
                3'd2: begin op = OP_PI2; ka = k5; end
                3'd3: op = OP_PI1;
                3'd4: begin op = OP_PI4; ka = k4; end
                3'd5: begin op = OP_PI3; ka = k2; kb = k3; end
                3'd6: begin op = OP_PI2; ka = k1; end
                default: op = OP_PI1;
            endcase
        end else begin
            case (step_reg)
                3'd0: op = OP_PI1;
                3'd1: begin op = OP_PI2; ka = k1; end
                3'd2: begin op = OP_PI3; ka = k2; kb = k3; end
                3'd3: begin op = OP_PI4; ka = k4; end
                3'd4: op = OP_PI1;
                3'd5: begin op = OP_PI2; ka = k5; end
                3'd6: begin op = OP_PI3; ka = k6; kb = k7; end
                default: begin op = OP_PI4; ka = k8; end
            endcase
        end
    end

    // one pi function
    always_comb begin
        l_step = l_reg;
        r_step = r_reg;
        y = '0;
        z = '0;
        a = '0;
        b = '0;
        c = '0;
        case (op)
            OP_PI1: r_step = r_reg ^ l_reg;
            OP_PI2: begin
                y = r_reg + ka;
                z = rotl(y, 1) + y - 32'd1;
                l_step = l_reg ^ rotl(z, 4) ^ z;
            end
            OP_PI3: begin
                y = l_reg + ka;
                z = rotl(y, 2) + y + 32'd1;
                a = rotl(z, 8) ^ z;
                b = a + kb;
                c = rotl(b, 1) - b;
                r_step = r_reg ^ rotl(c, 16) ^ (c | l_reg);
            end
            OP_PI4: begin
                y = r_reg + ka;
                l_step = l_reg ^ (rotl(y, 2) + y + 32'd1);
            end
            default: ;
        endcase
    end

    // final xor
    always_comb begin
        case (job_reg.mode)
            m2cbc_pkg::MODE_CBC: result = {l_reg, r_reg} ^ job_reg.chain;
            m2cbc_pkg::MODE_OFB: result = (job_reg.block ^ {l_reg, r_reg})
                                          & lead_mask(job_reg.count);
            default:             result = '0;
        endcase
    end

    assign last_step = (step_reg == STEP_LAST) && (round_reg == RND_W'(ROUNDS - 1));
    assign out_free  = !out_valid_reg || m_tready;
    assign can_pop   = !q_status.empty &&
                       ((state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free));
    assign q_pop     = can_pop;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        step_next      = step_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE: ;
            ST_RUN: begin
                l_next    = l_step;
                r_next    = r_step;
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST) begin
                    round_next = round_reg + 1'b1;
                end
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(m2cbc_pkg::TDATA_W - BW - CW){1'b0}},
                                      job_reg.count, result};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // load the next job
        if (can_pop) begin
            job_next   = q_job;
            step_next  = '0;
            round_next = '0;
            if (q_job.mode == m2cbc_pkg::MODE_CBC) begin
                {l_next, r_next} = q_job.block;
            end else begin
                {l_next, r_next} = q_job.chain;
            end
            state_next = (q_job.mode == m2cbc_pkg::MODE_ZERO) ? ST_DONE : ST_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    a_pop_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free))
        else $error("job taken while engine busy");

    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && last_step |=> (state_reg == ST_DONE))
        else $error("engine did not finish after last round");

    a_run_not_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (job_reg.mode != m2cbc_pkg::MODE_ZERO))
        else $error("empty item sent through rounds");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && !out_free |=> (state_reg == ST_DONE) && $stable(l_reg))
        else $error("finished job lost while output stalled");

endmodule

### rtl/multi2_cbc_ofb_decrypt.sv
// Top level of the MULTI2 CBC decryptor with OFB residual handling.
// Joins m2cbc_front, m2cbc_queue and m2cbc_engine; depends on m2cbc_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  cfg      | in        | cfg_valid/ready    | cfg_index[2:0], cfg_data[63:0]
//  s_       | in        | s_tvalid/tready    | tdata: cipher_block, byte_count; tuser: packet_start
//  m_       | out       | m_tvalid/tready    | tdata: plain_block, plain_count
//
// A full block or residual is loaded and run through the round engine one pi function
// a cycle; an empty beat is loaded straight into the done state and skips the rounds.
// Reset is synchronous on aresetn low; keys, IV and chaining register clear to zero.
// A two-entry job queue decouples input from the engine, and the output register holds
// a finished result while m_tready is low without blocking the next job.
module multi2_cbc_ofb_decrypt #(
    parameter int ROUNDS = m2cbc_pkg::DEFAULT_ROUNDS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [m2cbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [m2cbc_pkg::BLOCK_W-1:0]          cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [m2cbc_pkg::TDATA_W-1:0]          s_tdata,  // [63:0] cipher_block, [67:64] byte_count
    input  logic                                   s_tuser,  // [0] packet_start
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [m2cbc_pkg::TDATA_W-1:0]          m_tdata   // [63:0] plain_block, [67:64] plain_count
);

    m2cbc_pkg::key_set_t       keys;
    m2cbc_pkg::queue_status_t  q_status;
    m2cbc_pkg::job_t           push_job, pop_job;
    logic                      q_push, q_pop;

    m2cbc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_job     (push_job),
        .keys      (keys)
    );

    m2cbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    m2cbc_engine #(
        .ROUNDS (ROUNDS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .keys     (keys),
        .q_status (q_status),
        .q_pop    (q_pop),
        .q_job    (pop_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### test/tb_multi2_cbc_ofb_decrypt.sv
// Self-checking testbench for multi2_cbc_ofb_decrypt: CBC blocks and OFB residuals
// are driven from a queue, and results are checked against an in-bench MULTI2 model.
// Depends on m2cbc_pkg and the RTL top level only.
module tb_multi2_cbc_ofb_decrypt;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_W     = m2cbc_pkg::BLOCK_W;
    localparam int COUNT_W     = m2cbc_pkg::COUNT_W;
    localparam int TDATA_W     = m2cbc_pkg::TDATA_W;
    localparam int CFG_INDEX_W = m2cbc_pkg::CFG_INDEX_W;
    localparam logic [COUNT_W-1:0] FULL_COUNT = m2cbc_pkg::FULL_COUNT;

    localparam int ROUND_COUNT   = m2cbc_pkg::DEFAULT_ROUNDS;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 305;
    localparam int REPORT_LIMIT  = 10;

    // One ciphertext beat waiting to go out; hold_off waits for all results first
    typedef struct {
        logic [BLOCK_W-1:0] block;
        logic [COUNT_W-1:0] count;
        logic               start;
        bit                 hold_off;
    } cipher_beat_t;

    typedef struct {
        logic [BLOCK_W-1:0] plain;
        logic [COUNT_W-1:0] count;
    } plain_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BLOCK_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    // Shadow copies of the key registers, IV and chaining register
    logic [BLOCK_W-1:0] key_shadow [0:3];
    logic [BLOCK_W-1:0] iv_shadow = '0;
    logic [BLOCK_W-1:0] chain_shadow = '0;

    cipher_beat_t cipher_pending[$];
    cipher_beat_t on_bus;
    plain_beat_t  plain_expect[$];
    plain_beat_t  plain_want;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    multi2_cbc_ofb_decrypt #(
        .ROUNDS(ROUND_COUNT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- MULTI2 model
    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Work key word 1..8; odd words sit in the upper half of each register
    function automatic logic [31:0] key_word(input int n);
        logic [BLOCK_W-1:0] pair;
        pair = key_shadow[(n - 1) / 2];
        return (n % 2 == 1) ? pair[63:32] : pair[31:0];
    endfunction

    function automatic logic [31:0] mix2(input logic [31:0] l, input logic [31:0] r,
                                         input logic [31:0] k);
        logic [31:0] y, z;
        y = r + k;
        z = rotl(y, 1) + y - 32'd1;
        return l ^ rotl(z, 4) ^ z;
    endfunction

    function automatic logic [31:0] mix3(input logic [31:0] l, input logic [31:0] r,
                                         input logic [31:0] ka, input logic [31:0] kb);
        logic [31:0] y, z, a, b, c;
        y = l + ka;
        z = rotl(y, 2) + y + 32'd1;
        a = rotl(z, 8) ^ z;
        b = a + kb;
        c = rotl(b, 1) - b;
        return r ^ rotl(c, 16) ^ (c | l);
    endfunction

    function automatic logic [31:0] mix4(input logic [31:0] l, input logic [31:0] r,
                                         input logic [31:0] k);
        logic [31:0] y;
        y = r + k;
        return l ^ (rotl(y, 2) + y + 32'd1);
    endfunction

    function automatic logic [BLOCK_W-1:0] decipher(input logic [BLOCK_W-1:0] v);
        logic [31:0] l, r;
        l = v[63:32];
        r = v[31:0];
        for (int i = 0; i < ROUND_COUNT; i++) begin
            l = mix4(l, r, key_word(8));
            r = mix3(l, r, key_word(6), key_word(7));
            l = mix2(l, r, key_word(5));
            r = r ^ l;
            l = mix4(l, r, key_word(4));
            r = mix3(l, r, key_word(2), key_word(3));
            l = mix2(l, r, key_word(1));
            r = r ^ l;
        end
        return {l, r};
    endfunction

    function automatic logic [BLOCK_W-1:0] encipher(input logic [BLOCK_W-1:0] v);
        logic [31:0] l, r;
        l = v[63:32];
        r = v[31:0];
        for (int i = 0; i < ROUND_COUNT; i++) begin
            r = r ^ l;
            l = mix2(l, r, key_word(1));
            r = mix3(l, r, key_word(2), key_word(3));
            l = mix4(l, r, key_word(4));
            r = r ^ l;
            l = mix2(l, r, key_word(5));
            r = mix3(l, r, key_word(6), key_word(7));
            l = mix4(l, r, key_word(8));
        end
        return {l, r};
    endfunction

    // Works out the plaintext of one accepted beat and advances the chain
    function automatic void predict_plain(input cipher_beat_t beat);
        plain_beat_t res;
        int n;
        if (beat.start)
            chain_shadow = iv_shadow;
        n = (beat.count > FULL_COUNT) ? int'(FULL_COUNT) : int'(beat.count);
        res.count = COUNT_W'(n);
        res.plain = '0;
        if (n == int'(FULL_COUNT)) begin
            res.plain = decipher(beat.block) ^ chain_shadow;
            chain_shadow = beat.block;
        end else if (n > 0) begin
            res.plain = (beat.block ^ encipher(chain_shadow)) & (~64'd0 << (64 - 8 * n));
        end
        plain_expect.push_back(res);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ---------------------------------------------------------------- input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_plain(on_bus);
            if (!s_tvalid || s_tready) begin
                if (cipher_pending.size() != 0 && $urandom_range(99) >= send_gap_pct
                        && !(cipher_pending[0].hold_off && plain_expect.size() != 0)) begin
                    on_bus = cipher_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(TDATA_W - BLOCK_W - COUNT_W){1'b0}}, on_bus.count,
                                on_bus.block};
                    s_tuser <= on_bus.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (plain_expect.size() == 0) begin
                    note_failure($sformatf("unexpected result beat tdata=%h", m_tdata));
                end else begin
                    plain_want = plain_expect.pop_front();
                    if (m_tdata[BLOCK_W-1:0] !== plain_want.plain
                            || m_tdata[BLOCK_W+COUNT_W-1:BLOCK_W] !== plain_want.count)
                        note_failure($sformatf(
                            "mismatch: plain exp %h got %h, count exp %0d got %0d",
                            plain_want.plain, m_tdata[BLOCK_W-1:0], plain_want.count,
                            m_tdata[BLOCK_W+COUNT_W-1:BLOCK_W]));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BLOCK_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            m2cbc_pkg::CFG_KEY_12: key_shadow[0] = value;
            m2cbc_pkg::CFG_KEY_34: key_shadow[1] = value;
            m2cbc_pkg::CFG_KEY_56: key_shadow[2] = value;
            m2cbc_pkg::CFG_KEY_78: key_shadow[3] = value;
            m2cbc_pkg::CFG_IV:     iv_shadow = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [BLOCK_W-1:0] k12, input logic [BLOCK_W-1:0] k34,
                                 input logic [BLOCK_W-1:0] k56, input logic [BLOCK_W-1:0] k78,
                                 input logic [BLOCK_W-1:0] iv);
        write_reg(m2cbc_pkg::CFG_KEY_12, k12);
        write_reg(m2cbc_pkg::CFG_KEY_34, k34);
        write_reg(m2cbc_pkg::CFG_KEY_56, k56);
        write_reg(m2cbc_pkg::CFG_KEY_78, k78);
        write_reg(m2cbc_pkg::CFG_IV, iv);
    endtask

    function automatic void queue_beat(input logic [BLOCK_W-1:0] block,
                                       input int count, input bit start, input bit hold_off);
        cipher_beat_t beat;
        beat.block = block;
        beat.count = COUNT_W'(count);
        beat.start = start;
        beat.hold_off = hold_off;
        cipher_pending.push_back(beat);
    endfunction

    function automatic logic [BLOCK_W-1:0] rand_block();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Block until the bench has nothing in flight; checked mid-cycle so that
    // a beat launched at the last rising edge is already visible on s_tvalid
    task automatic wait_drained();
        while (cipher_pending.size() != 0 || s_tvalid || plain_expect.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly well-formed packets: CBC blocks, optional residual; some noise beats
    task automatic run_random_phase(input int gap_pct, input int stall_pct);
        int made;
        int roll;
        int len;
        bit fresh;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        made = 0;
        while (made < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                queue_beat(rand_block(), $urandom_range(15), $urandom_range(1), 1'b0);
                made++;
            end else begin
                len = (roll < 80) ? $urandom_range(1, 4) : $urandom_range(5, 16);
                fresh = ($urandom_range(9) != 0);
                for (int j = 0; j < len; j++)
                    queue_beat(rand_block(), FULL_COUNT, j == 0 && fresh,
                               (made == 0 && j == 0) || $urandom_range(59) == 0);
                made += len;
                if ($urandom_range(9) < 4) begin
                    queue_beat(rand_block(), $urandom_range(1, 7), 1'b0, 1'b0);
                    made++;
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < 4; i++)
            key_shadow[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed beats under the reset key set
        queue_beat('0, 8, 1'b1, 1'b0);
        queue_beat('1, 8, 1'b0, 1'b0);
        queue_beat(rand_block(), 7, 1'b0, 1'b0);
        queue_beat('1, 1, 1'b0, 1'b0);
        queue_beat(rand_block(), 0, 1'b1, 1'b0);
        queue_beat(rand_block(), 15, 1'b0, 1'b0);
        queue_beat(rand_block(), 9, 1'b0, 1'b0);
        wait_drained();

        // directed beats with every key and IV bit set
        load_settings('1, '1, '1, '1, '1);
        queue_beat('1, 8, 1'b1, 1'b0);
        queue_beat('0, 8, 1'b0, 1'b0);
        queue_beat(rand_block(), 8, 1'b0, 1'b1);
        queue_beat(rand_block(), 3, 1'b1, 1'b0);
        queue_beat(rand_block(), 12, 1'b1, 1'b0);
        queue_beat(rand_block(), 5, 1'b0, 1'b0);
        queue_beat(rand_block(), 0, 1'b0, 1'b0);
        queue_beat(rand_block(), 8, 1'b0, 1'b0);
        queue_beat(rand_block(), 2, 1'b0, 1'b0);
        queue_beat(rand_block(), 4, 1'b0, 1'b0);
        queue_beat(rand_block(), 6, 1'b0, 1'b0);
        wait_drained();

        // random phases with the idling patterns
        load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        run_random_phase(0, 0);
        load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        run_random_phase(53, 0);
        load_settings('0, '1, '0, '1, {$urandom, $urandom});
        run_random_phase(0, 53);
        load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, '0);
        run_random_phase(13, 13);

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && plain_expect.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
